/* rtl/bba_pkg.sv */
package bba_pkg;
    localparam int ADDR_BITS   = 40;
    localparam int STACK_DEPTH = 64;
    localparam int MIN_ORDER   = 5;
    localparam int MAX_ORDER   = 16;
    localparam int NUM_ORDERS  = MAX_ORDER - MIN_ORDER + 1;
    localparam int SP_BITS     = $clog2(STACK_DEPTH);
    localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);
    localparam int ORD_BITS    = $clog2(NUM_ORDERS);
    localparam int MEM_DEPTH   = NUM_ORDERS * STACK_DEPTH;
    localparam int MEM_ABITS   = $clog2(MEM_DEPTH);
    localparam int SIZE_BITS   = 40;
    localparam int LG_BITS     = 6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NULL = 2'd1;
    localparam logic [1:0] ST_OOM  = 2'd2;

    localparam logic [0:0] CFG_START = 1'b0;
    localparam logic [0:0] CFG_END   = 1'b1;

    typedef logic [ADDR_BITS-1:0] t_addr;

    typedef struct packed {
        logic                 push;
        logic [ORD_BITS-1:0]  ord;
        t_addr                addr;
    } t_push;

    typedef struct packed {
        logic                 pop;
        logic [ORD_BITS-1:0]  ord;
    } t_pop;

    typedef struct packed {
        logic                 done;
        t_addr                addr;
    } t_pop_rsp;
endpackage

/* rtl/bba_if.sv */
interface bba_req_if;
    logic        valid;
    logic        ready;
    logic [39:0] request_size;
    logic [5:0]  align_log2;
    modport source (output valid, request_size, align_log2, input ready);
    modport sink   (input valid, request_size, align_log2, output ready);
endinterface

interface bba_rsp_if;
    logic        valid;
    logic        ready;
    logic [39:0] block_address;
    logic [1:0]  status;
    logic [39:0] bump_pointer;
    modport source (output valid, block_address, status, bump_pointer, input ready);
    modport sink   (input valid, block_address, status, bump_pointer, output ready);
endinterface

/* rtl/bba_ram.sv */
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/bba_stacks.sv */
// Free stacks: one RAM partitioned per order, with counts in flip-flops.
// One push or one pop per cycle; a pop answers in the next cycle.
module bba_stacks (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear,
    input  bba_pkg::t_push     i_push,
    input  bba_pkg::t_pop      i_pop,
    output bba_pkg::t_pop_rsp  o_pop_rsp,
    output logic [bba_pkg::NUM_ORDERS-1:0] o_nonempty,
    output logic [bba_pkg::NUM_ORDERS-1:0] o_full
);
    import bba_pkg::*;

    logic [CNT_BITS-1:0]  r_cnt [NUM_ORDERS];
    logic                 r_pop_done;
    logic                 mem_we;
    logic [MEM_ABITS-1:0] mem_waddr;
    logic [MEM_ABITS-1:0] mem_raddr;
    t_addr                mem_rdata;
    logic [CNT_BITS-1:0]  pcnt;
    logic [CNT_BITS-1:0]  qcnt;

    always_comb begin
        pcnt = r_cnt[i_push.ord];
        qcnt = r_cnt[i_pop.ord] - CNT_BITS'(1);
        mem_we = i_push.push && (pcnt != CNT_BITS'(STACK_DEPTH));
        mem_waddr = MEM_ABITS'(MEM_ABITS'(i_push.ord) * MEM_ABITS'(STACK_DEPTH)
                    + MEM_ABITS'(pcnt));
        mem_raddr = MEM_ABITS'(MEM_ABITS'(i_pop.ord) * MEM_ABITS'(STACK_DEPTH)
                    + MEM_ABITS'(qcnt));
        for (int i = 0; i < NUM_ORDERS; i++) begin
            o_nonempty[i] = r_cnt[i] != '0;
            o_full[i]     = r_cnt[i] == CNT_BITS'(STACK_DEPTH);
        end
    end

    bba_ram #(.WIDTH(ADDR_BITS), .DEPTH(MEM_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_push.addr),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int i = 0; i < NUM_ORDERS; i++) r_cnt[i] <= '0;
            r_pop_done <= 1'b0;
        end else begin
            r_pop_done <= i_pop.pop;
            if (i_pop.pop) begin
                r_cnt[i_pop.ord] <= qcnt;
            end else if (mem_we) begin
                r_cnt[i_push.ord] <= pcnt + CNT_BITS'(1);
            end
        end
    end

    assign o_pop_rsp.done = r_pop_done;
    assign o_pop_rsp.addr = mem_rdata;
endmodule

/* rtl/buddy_bump_allocator.sv */
// Channel   Dir  Fields
// s_req     in   request_size[39:0], align_log2[5:0]
// m_rsp     out  block_address[39:0], status[1:0], bump_pointer[39:0]
// cfg       in   i_cfg_we, i_cfg_index, i_cfg_data[39:0]
// One request at a time. A stack hit passes through S_CLASS, S_SEARCH, S_POPW and
// S_SPLIT, which pushes one buddy per step, then S_DONE. A bump allocation passes
// S_ALIGN and S_CHECK, then S_GAP pushes one gap chunk per step; an order-16 run
// pushes at most 64 chunks in S_GAPRUN. Out of memory goes from S_CHECK to S_DONE.
// Synchronous reset empties all stacks; no clearing pass is needed.
// The result register holds while m_rsp.ready is low; the next request waits.
module buddy_bump_allocator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [39:0]      i_cfg_data,
    bba_req_if.sink          s_req,
    bba_rsp_if.source        m_rsp
);
    import bba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLASS, S_SEARCH, S_POPW, S_SPLIT, S_ALIGN, S_CHECK,
        S_GAP, S_GAPRUN, S_DONE, S_OUT
    } t_state;

    t_state                r_state;
    t_addr                 r_end, r_next;
    logic [SIZE_BITS-1:0]  r_size;
    logic [LG_BITS-1:0]    r_lg;
    logic [ORD_BITS-1:0]   r_ord, r_k;
    t_addr                 r_addr, r_asz;
    logic                  r_ok;
    t_addr                 r_gs, r_ge;
    logic [SP_BITS:0]      r_run;
    logic                  r_big;
    logic [39:0]           r_o_addr, r_o_bump;
    logic [1:0]            r_o_st;
    logic                  r_o_valid;

    t_push                 push;
    t_pop                  pop;
    t_pop_rsp              pop_rsp;
    logic [NUM_ORDERS-1:0] nonempty, full;
    logic                  clear;

    assign clear = i_cfg_we && i_cfg_index == CFG_START;

    bba_stacks u_stacks (
        .i_clk, .i_rst_n, .i_clear(clear),
        .i_push(push), .i_pop(pop), .o_pop_rsp(pop_rsp),
        .o_nonempty(nonempty), .o_full(full)
    );

    localparam t_addr AMASK   = '1;
    localparam t_addr MINM    = t_addr'((64'd1 << MIN_ORDER) - 64'd1);

    // rounded order of the request; NUM_ORDERS means "large"
    function automatic logic [ORD_BITS:0] size_ord(input logic [SIZE_BITS-1:0] s);
        logic [ORD_BITS:0] o;
        o = (ORD_BITS+1)'(NUM_ORDERS);
        for (int j = NUM_ORDERS - 1; j >= 0; j--) begin
            if ({24'd0, s} <= (64'd1 << (j + MIN_ORDER))) o = (ORD_BITS+1)'(j);
        end
        return o;
    endfunction

    // largest aligned chunk at gs that fits in ge-gs
    logic [ORD_BITS-1:0] g_ord;
    logic                g_fit;
    t_addr               g_len;
    always_comb begin
        g_len = r_ge - r_gs;
        g_ord = '0;
        for (int j = 1; j < NUM_ORDERS; j++) begin
            if ((t_addr'(64'd1 << (j + MIN_ORDER)) <= g_len) &&
                ((r_gs & t_addr'((64'd1 << (j + MIN_ORDER)) - 64'd1)) == '0))
                g_ord = ORD_BITS'(j);
        end
        g_fit = (r_gs < r_ge) && (g_len > MINM);
    end

    logic [ORD_BITS:0] sord;
    logic [ORD_BITS-1:0] k_next;
    logic              k_found;
    always_comb begin
        sord = size_ord(s_req.request_size);
        k_found = 1'b0;
        k_next = r_ord;
        for (int j = NUM_ORDERS - 1; j >= 0; j--) begin
            if (ORD_BITS'(j) >= r_ord && nonempty[j]) begin
                k_found = 1'b1;
                k_next = ORD_BITS'(j);
            end
        end
    end

    // align r_next up by 2^r_lg
    t_addr al_m, al_b, al_a;
    logic  al_ok;
    t_addr al_res;
    always_comb begin
        al_a = t_addr'(64'd1 << r_lg);
        al_m = al_a - t_addr'(1);
        al_b = r_next & ~al_m;
        al_ok = 1'b1;
        al_res = al_b;
        if ({58'd0, r_lg} >= 64'(ADDR_BITS)) begin
            al_res = '0;
            al_ok = r_next == '0;
        end else if (al_b != r_next) begin
            al_ok = al_b <= AMASK - al_a;
            al_res = al_b + al_a;
        end
    end

    logic [SP_BITS:0] room;
    t_addr            nmax;
    always_comb begin
        nmax = g_len >> MAX_ORDER;
        room = (SP_BITS+1)'(STACK_DEPTH);
        if (nmax < t_addr'(STACK_DEPTH)) room = (SP_BITS+1)'(nmax);
    end

    always_comb begin
        push = '0;
        pop  = '0;
        case (r_state)
            S_SEARCH: begin
                pop.pop = k_found;
                pop.ord = k_next;
            end
            S_SPLIT: begin
                push.push = r_k != r_ord;
                push.ord  = r_k - ORD_BITS'(1);
                push.addr = r_addr + t_addr'(64'd1 << (r_k - ORD_BITS'(1) + MIN_ORDER));
            end
            S_GAP: begin
                push.push = g_fit && g_ord != ORD_BITS'(NUM_ORDERS - 1);
                push.ord  = g_ord;
                push.addr = r_gs;
            end
            S_GAPRUN: begin
                push.push = r_run != '0 && !full[NUM_ORDERS-1];
                push.ord  = ORD_BITS'(NUM_ORDERS - 1);
                push.addr = r_gs;
            end
            default: ;
        endcase
    end

    assign s_req.ready = r_state == S_IDLE;
    assign m_rsp.valid = r_o_valid;
    assign m_rsp.block_address = r_o_addr;
    assign m_rsp.status = r_o_st;
    assign m_rsp.bump_pointer = r_o_bump;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_end     <= '0;
            r_next    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_START) begin
                    if ((i_cfg_data & MINM) == '0) r_next <= i_cfg_data;
                    else if ((i_cfg_data | MINM) == AMASK) r_next <= AMASK;
                    else r_next <= (i_cfg_data | MINM) + t_addr'(1);
                end else begin
                    r_end <= i_cfg_data;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (s_req.valid) begin
                        r_size  <= s_req.request_size;
                        r_lg    <= s_req.align_log2;
                        r_ord   <= sord[ORD_BITS-1:0];
                        r_big   <= sord == (ORD_BITS+1)'(NUM_ORDERS);
                        r_state <= S_CLASS;
                    end
                end
                S_CLASS: begin
                    r_ok   <= 1'b1;
                    r_addr <= '0;
                    if (r_size == '0) begin
                        r_o_st  <= ST_NULL;
                        r_state <= S_DONE;
                    end else if (r_big) begin
                        r_asz   <= r_size;
                        r_state <= S_ALIGN;
                    end else begin
                        r_asz   <= t_addr'(64'd1 << (r_ord + MIN_ORDER));
                        r_lg    <= LG_BITS'(r_ord + MIN_ORDER);
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    r_k <= k_next;
                    r_state <= k_found ? S_POPW : S_ALIGN;
                end
                S_POPW: begin
                    if (pop_rsp.done) begin
                        r_addr  <= pop_rsp.addr;
                        r_state <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    if (r_k == r_ord) begin
                        r_o_st  <= ST_OK;
                        r_state <= S_DONE;
                    end else begin
                        r_k <= r_k - ORD_BITS'(1);
                    end
                end
                S_ALIGN: begin
                    r_ok    <= al_ok;
                    r_addr  <= al_res;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (!r_ok || r_asz > r_end || r_addr > r_end - r_asz) begin
                        r_o_st  <= ST_OOM;
                        r_addr  <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_gs <= ((r_next & MINM) != '0) ? ((r_next | MINM) + t_addr'(1))
                                                          : r_next;
                        r_ge <= r_addr;
                        // gap start rounding may pass the end: nothing freed then
                        if ((r_next & MINM) != '0 && (r_next | MINM) >= r_addr)
                            r_ge <= '0;
                        r_o_st  <= ST_OK;
                        r_state <= S_GAP;
                    end
                end
                S_GAP: begin
                    if (!g_fit) begin
                        r_next  <= r_addr + r_asz;
                        r_state <= S_DONE;
                    end else if (g_ord == ORD_BITS'(NUM_ORDERS - 1)) begin
                        r_run   <= room;
                        r_ge    <= r_ge;
                        r_state <= S_GAPRUN;
                        r_asz   <= r_asz;
                    end else begin
                        r_gs <= r_gs + t_addr'(64'd1 << (g_ord + MIN_ORDER));
                    end
                end
                S_GAPRUN: begin
                    if (r_run == '0 || full[NUM_ORDERS-1]) begin
                        // skip the rest of the max-order run
                        r_gs    <= r_gs + ((r_ge - r_gs) & ~t_addr'((64'd1 << MAX_ORDER) - 1));
                        r_state <= S_GAP;
                    end else begin
                        r_gs  <= r_gs + t_addr'(64'd1 << MAX_ORDER);
                        r_run <= r_run - (SP_BITS+1)'(1);
                    end
                end
                S_DONE: begin
                    r_o_addr  <= (r_o_st == ST_OK) ? r_addr : '0;
                    r_o_bump  <= r_next;
                    r_o_valid <= 1'b1;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (m_rsp.ready) begin
                        r_o_valid <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/bba_checker.sv */
module bba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [39:0] rsp_addr,
    input logic [1:0]  rsp_status
);
    import bba_pkg::*;

    a_no_ready_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !req_ready) else $error("request taken while result pending");
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |=> !req_ready) else $error("second request taken");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_addr == '0) else $error("addr not zero");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> rsp_status != 2'd3) else $error("bad status");
endmodule

bind buddy_bump_allocator bba_checker u_chk (
    .i_clk, .i_rst_n,
    .req_valid(s_req.valid), .req_ready(s_req.ready),
    .rsp_valid(m_rsp.valid), .rsp_ready(m_rsp.ready),
    .rsp_addr(m_rsp.block_address), .rsp_status(m_rsp.status)
);

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
    import bba_pkg::*;

    localparam logic [63:0] AMASK = 64'hFF_FFFF_FFFF;
    localparam int WATCHDOG = 20000;

    typedef enum int {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e   kind;
        logic [63:0] size;    // request size, or register data
        int unsigned lg;      // align_log2, or register index
        bit          typed;
        logic [39:0] e_addr;
        logic [1:0]  e_status;
    } stim_row_t;

    typedef struct {
        logic [39:0] addr;
        logic [1:0]  status;
        logic [39:0] bump;
    } alloc_rsp_t;

    typedef struct {
        bit          typed;
        logic [39:0] addr;
        logic [1:0]  status;
    } typed_note_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [39:0] i_cfg_data = '0;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    buddy_bump_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_req       (req_ch.sink),
        .m_rsp       (rsp_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // allocator shadow state
    logic [39:0] chunk_mem [NUM_ORDERS][STACK_DEPTH];
    int unsigned chunk_cnt [NUM_ORDERS];
    logic [63:0] rgn_start, rgn_end, bump_ptr;

    alloc_rsp_t  alloc_q [$];
    typed_note_t note_q [$];
    int          fails = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_go = 1'b0;
    bit          hold_taken = 1'b0;
    int          hold_cnt = 0;
    int          quiet_cycles = 0;

    function automatic bit align_up(input logic [63:0] x, input int unsigned lg,
                                    output logic [63:0] r);
        logic [63:0] a, b;
        if (lg >= ADDR_BITS) begin
            r = 0;
            return x == 0;
        end
        a = 64'd1 << lg;
        b = x & ~(a - 1);
        if (b != x) begin
            if (b > AMASK - a) return 1'b0;
            b += a;
        end
        r = b;
        return 1'b1;
    endfunction

    function automatic void push_chunk(input int o, input logic [63:0] a);
        int i;
        i = o - MIN_ORDER;
        if (i < 0 || i >= NUM_ORDERS) return;
        if (chunk_cnt[i] < STACK_DEPTH) begin
            chunk_mem[i][chunk_cnt[i]] = a[39:0];
            chunk_cnt[i]++;
        end
    endfunction

    // carve a skipped gap into naturally aligned chunks
    function automatic void carve_gap(input logic [63:0] s, input logic [63:0] e);
        logic [63:0] minsz, sz, n, room, k;
        int o;
        minsz = 64'd1 << MIN_ORDER;
        if ((s & (minsz - 1)) != 0) begin
            if ((s | (minsz - 1)) >= e) return;
            s = (s | (minsz - 1)) + 1;
        end
        while (s < e && e - s >= minsz) begin
            o = MAX_ORDER;
            while (o > MIN_ORDER) begin
                sz = 64'd1 << o;
                if (sz <= e - s && (s & (sz - 1)) == 0) break;
                o--;
            end
            if (o == MAX_ORDER) begin
                n = (e - s) >> MAX_ORDER;
                room = STACK_DEPTH - chunk_cnt[NUM_ORDERS-1];
                k = n < room ? n : room;
                for (logic [63:0] j = 0; j < k; j++)
                    push_chunk(MAX_ORDER, s + (j << MAX_ORDER));
                s += n << MAX_ORDER;
            end else begin
                push_chunk(o, s);
                s += 64'd1 << o;
            end
        end
    endfunction

    function automatic bit bump_alloc(input logic [63:0] size, input int unsigned lg,
                                      output logic [63:0] addr);
        logic [63:0] a;
        addr = 0;
        if (!align_up(bump_ptr, lg, a)) return 1'b0;
        if (size > rgn_end || a > rgn_end - size) return 1'b0;
        if (a > bump_ptr) carve_gap(bump_ptr, a);
        bump_ptr = a + size;
        addr = a;
        return 1'b1;
    endfunction

    function automatic alloc_rsp_t predict_alloc(input logic [39:0] size_in,
                                                 input logic [5:0] lg);
        alloc_rsp_t r;
        logic [63:0] size, addr;
        int ord, k, i;
        size = {24'd0, size_in};
        addr = 0;
        r.status = ST_OK;
        ord = MIN_ORDER;
        if (size == 0) begin
            r.status = ST_NULL;
        end else begin
            while (ord <= MAX_ORDER && (64'd1 << ord) < size) ord++;
            if (ord <= MAX_ORDER) begin
                k = ord;
                while (k <= MAX_ORDER && chunk_cnt[k-MIN_ORDER] == 0) k++;
                if (k <= MAX_ORDER) begin
                    i = k - MIN_ORDER;
                    chunk_cnt[i]--;
                    addr = {24'd0, chunk_mem[i][chunk_cnt[i]]};
                    for (int o = k - 1; o >= ord; o--)
                        push_chunk(o, addr + (64'd1 << o));
                end else if (!bump_alloc(64'd1 << ord, ord, addr)) begin
                    r.status = ST_OOM;
                end
            end else if (!bump_alloc(size, lg, addr)) begin
                r.status = ST_OOM;
            end
        end
        r.addr = (r.status == ST_OK) ? addr[39:0] : '0;
        r.bump = bump_ptr[39:0];
        return r;
    endfunction

    function automatic void apply_cfg(input logic [0:0] idx, input logic [63:0] v);
        if (idx == CFG_START) begin
            rgn_start = v & AMASK;
            foreach (chunk_cnt[i]) chunk_cnt[i] = 0;
            if (!align_up(rgn_start, MIN_ORDER, bump_ptr)) bump_ptr = AMASK;
        end else begin
            rgn_end = v & AMASK;
        end
    endfunction

    function automatic logic [63:0] rnd40();
        return {24'd0, 8'($urandom), 32'($urandom)};
    endfunction

    // receiver side
    always @(posedge i_clk) begin
        if (hold_go && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_cnt <= 400;
            rsp_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor: predict on request transactions, check response transactions
    always @(posedge i_clk) begin
        alloc_rsp_t exp_r, got;
        typed_note_t note;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                exp_r = predict_alloc(req_ch.request_size, req_ch.align_log2);
                note = note_q.pop_front();
                if (note.typed) begin
                    if (note.addr != exp_r.addr || note.status != exp_r.status) begin
                        $error("typed row disagrees with prediction: %h/%0d vs %h/%0d",
                               note.addr, note.status, exp_r.addr, exp_r.status);
                        fails++;
                    end
                    exp_r.addr = note.addr;
                    exp_r.status = note.status;
                end
                alloc_q.push_back(exp_r);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.addr = rsp_ch.block_address;
                got.status = rsp_ch.status;
                got.bump = rsp_ch.bump_pointer;
                if (alloc_q.size() == 0) begin
                    $error("response with no request outstanding");
                    fails++;
                end else begin
                    exp_r = alloc_q.pop_front();
                    if (got.addr !== exp_r.addr) begin
                        $error("block_address: expected %h, got %h", exp_r.addr, got.addr);
                        fails++;
                    end
                    if (got.status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, got.status);
                        fails++;
                    end
                    if (got.bump !== exp_r.bump) begin
                        $error("bump_pointer: expected %h, got %h", exp_r.bump, got.bump);
                        fails++;
                    end
                end
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("buddy_bump_allocator regression: fail");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [63:0] size, input int unsigned lg,
                             input bit typed, input logic [39:0] ea, input logic [1:0] es);
        typed_note_t n;
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        n.typed = typed;
        n.addr = ea;
        n.status = es;
        note_q.push_back(n);
        req_ch.valid <= 1'b1;
        req_ch.request_size <= size[39:0];
        req_ch.align_log2 <= lg[5:0];
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (alloc_q.size() != 0 || note_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [63:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v[39:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_cfg(idx, v);
        @(posedge i_clk);
    endtask

    stim_row_t dir_rows[] = '{
        // after reset the region is empty
        '{ROW_ITEM, 64'd0, 0, 1, 40'd0, ST_NULL},
        '{ROW_ITEM, 64'd1, 0, 1, 40'd0, ST_OOM},
        '{ROW_ITEM, AMASK, 39, 1, 40'd0, ST_OOM},
        '{ROW_CFG, 64'h100_0000, CFG_END, 0, 40'd0, ST_OK},
        '{ROW_CFG, 64'h13, CFG_START, 0, 40'd0, ST_OK},
        '{ROW_ITEM, 64'd1, 0, 1, 40'h20, ST_OK},
        '{ROW_ITEM, 64'd33, 7, 0, 40'd0, ST_OK},
        '{ROW_ITEM, 64'd100, 39, 0, 40'd0, ST_OK},
        '{ROW_ITEM, 64'h1_0000, 0, 0, 40'd0, ST_OK},
        '{ROW_ITEM, 64'h1_0001, 12, 0, 40'd0, ST_OK},
        '{ROW_ITEM, 64'h10_0000, 20, 0, 40'd0, ST_OK},
        '{ROW_ITEM, 64'd32, 0, 0, 40'd0, ST_OK},
        '{ROW_ITEM, 64'd200, 0, 0, 40'd0, ST_OK},
        '{ROW_ITEM, 64'h8000, 0, 0, 40'd0, ST_OK},
        '{ROW_ITEM, 64'h1_0000, 0, 0, 40'd0, ST_OK},
        '{ROW_ITEM, AMASK, 0, 1, 40'd0, ST_OOM},
        '{ROW_CFG, 64'd0, CFG_START, 0, 40'd0, ST_OK},
        '{ROW_CFG, AMASK, CFG_END, 0, 40'd0, ST_OK},
        '{ROW_ITEM, 64'h2_0000, 39, 1, 40'd0, ST_OK},
        '{ROW_ITEM, 64'h10_0000, 39, 0, 40'd0, ST_OK},
        '{ROW_ITEM, 64'd0, 39, 1, 40'd0, ST_NULL},
        '{ROW_CFG, AMASK, CFG_START, 0, 40'd0, ST_OK},
        '{ROW_ITEM, 64'd1, 0, 1, 40'd0, ST_OOM},
        '{ROW_ITEM, 64'h1_0000, 5, 1, 40'd0, ST_OOM}
    };

    initial begin
        logic [63:0] s, e, size;
        int unsigned lg, r;
        req_ch.valid = 1'b0;
        req_ch.request_size = '0;
        req_ch.align_log2 = '0;
        rgn_start = 0;
        rgn_end = 0;
        bump_ptr = 0;
        foreach (chunk_cnt[i]) chunk_cnt[i] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain();
                write_reg(dir_rows[i].lg[0], dir_rows[i].size);
            end else begin
                send_item(dir_rows[i].size, dir_rows[i].lg, dir_rows[i].typed,
                          dir_rows[i].e_addr, dir_rows[i].e_status);
            end
        end

        for (int ph = 0; ph < 5; ph++) begin
            drain();
            case (ph)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 66; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 66; end
                3: begin idle_pct = 29; stall_pct = 29; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            if (ph == 3) begin
                s = 0;
                e = AMASK;
            end else begin
                s = rnd40() >> $urandom_range(2, 30);
                e = s + (64'd1 << $urandom_range(18, 28));
                if (e > AMASK) e = AMASK;
            end
            write_reg(CFG_END, e);
            write_reg(CFG_START, s);
            if (ph == 4) hold_go = 1'b1;
            for (int n = 0; n < 106; n++) begin
                r = $urandom_range(99);
                lg = $urandom_range(0, 39);
                if (r < 6) size = 0;
                else if (r < 70) size = $urandom_range(1, 1 << $urandom_range(0, 16));
                else if (r < 90) begin
                    size = $urandom_range(65537, 1 << 22);
                    lg = $urandom_range(0, 24);
                end else size = rnd40();
                send_item(size, lg, 1'b0, '0, ST_OK);
            end
        end

        drain();
        if (fails == 0)
            $display("buddy_bump_allocator regression: pass");
        else
            $display("buddy_bump_allocator regression: fail");
        $finish;
    end
endmodule
